>>> sv/b64d_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 stream decoder.
package b64d_pkg;

	// Padding character '='.
	localparam logic [7:0] CHAR_PAD = 8'h3D;

	// Default depth of the queue between the front and the back.
	localparam int B64D_QUEUE_DEPTH = 4;

	// Status codes carried on every result.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CHAR = 2'd1,
		ST_BAD_LEN  = 2'd2,
		ST_BAD_PAD  = 2'd3
	} b64d_status_t;

	// One queue entry: a completed quartet or a single error result.
	typedef struct packed {
		logic [23:0]  word;      // three decoded bytes, first byte in the top bits
		logic [1:0]   last_idx;  // index of the final byte to emit (0 to 2)
		logic         msg_last;  // the entry closes the message
		b64d_status_t status;
	} b64d_entry_t;

	// Push request from the front into the queue.
	typedef struct packed {
		logic        push;
		b64d_entry_t entry;
	} b64d_push_t;

	// Maps a character to {invalid, sextet}; '=' counts as invalid here.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			return {1'b0, d[5:0]};
		end
		if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h47;
			return {1'b0, d[5:0]};
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			d = c + 8'h04;
			return {1'b0, d[5:0]};
		end
		if (c == 8'h2B) begin
			return {1'b0, 6'd62};
		end
		if (c == 8'h2F) begin
			return {1'b0, 6'd63};
		end
		return {1'b1, 6'd0};
	endfunction

endpackage

>>> sv/b64d_front.sv
// Front of the decoder: accepts characters, checks them and builds queue entries.
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       msg_end,
	input  logic       queue_full,
	output b64d_push_t push_o
);

	logic [17:0] acc_q;
	logic [1:0]  pos_q;
	logic [1:0]  pad_q;
	logic        drain_q;

	logic        take;
	logic [6:0]  lookup;
	logic        is_pad;
	logic [5:0]  sx;
	logic [1:0]  pad_n;
	logic        err;
	b64d_status_t err_code;
	logic        quartet_done;

	assign in_ready = !queue_full;
	assign take     = in_valid && in_ready;
	assign lookup   = sextet_of(in_char);
	assign is_pad   = (in_char == CHAR_PAD);
	assign sx       = is_pad ? 6'd0 : lookup[5:0];
	assign pad_n    = pad_q + {1'b0, is_pad};

	// Classify the character against the quartet state, in order of precedence.
	always_comb begin
		err          = 1'b0;
		err_code     = ST_OK;
		quartet_done = 1'b0;
		if (!drain_q) begin
			if (!is_pad && lookup[6]) begin
				err      = 1'b1;
				err_code = ST_BAD_CHAR;
			end else if (!is_pad && pad_q != 2'd0) begin
				err      = 1'b1;
				err_code = ST_BAD_PAD;
			end else if (is_pad && pos_q < 2'd2) begin
				err      = 1'b1;
				err_code = ST_BAD_PAD;
			end else if (pos_q != 2'd3) begin
				if (msg_end) begin
					err      = 1'b1;
					err_code = ST_BAD_LEN;
				end
			end else if (pad_n != 2'd0 && !msg_end) begin
				err      = 1'b1;
				err_code = ST_BAD_PAD;
			end else begin
				quartet_done = 1'b1;
			end
		end
	end

	// Queue entry for an error result or a completed quartet.
	always_comb begin
		push_o.push           = take && (err || quartet_done);
		push_o.entry.word     = err ? 24'd0 : {acc_q, sx};
		push_o.entry.last_idx = err ? 2'd0 : 2'd2 - pad_n;
		push_o.entry.msg_last = err ? 1'b1 : msg_end;
		push_o.entry.status   = err_code;
	end

	// Quartet state and the drain flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 18'd0;
			pos_q   <= 2'd0;
			pad_q   <= 2'd0;
			drain_q <= 1'b0;
		end else if (take) begin
			if (drain_q) begin
				if (msg_end) begin
					drain_q <= 1'b0;
				end
			end else if (err) begin
				acc_q   <= 18'd0;
				pos_q   <= 2'd0;
				pad_q   <= 2'd0;
				drain_q <= !msg_end;
			end else if (quartet_done) begin
				acc_q <= 18'd0;
				pos_q <= 2'd0;
				pad_q <= 2'd0;
			end else begin
				acc_q <= {acc_q[11:0], sx};
				pos_q <= pos_q + 2'd1;
				pad_q <= pad_n;
			end
		end
	end

`ifndef SYNTHESIS
	a_drain_clean: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (pos_q == 2'd0 && pad_q == 2'd0 && acc_q == 18'd0))
		else $error("quartet state not clear while draining");
	a_pad_place: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != 2'd0) |-> (pos_q == 2'd3 && pad_q == 2'd1))
		else $error("padding count held outside the last quartet position");
	a_ok_on_fourth: assert property (@(posedge clk) disable iff (!arst_n)
		(push_o.push && push_o.entry.status == ST_OK) |-> (take && pos_q == 2'd3))
		else $error("quartet pushed before its fourth character");
`endif

endmodule

>>> sv/b64d_queue.sv
// Short register queue that decouples the front from the back.
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int DEPTH = B64D_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  b64d_push_t  push_i,
	input  logic        pop,
	output logic        full,
	output logic        head_valid,
	output b64d_entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64d_entry_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != CW'(0));
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push_i.push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_i.entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/b64d_back.sv
// Back of the decoder: turns queue entries into results through an output register.
module b64d_back
	import b64d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  b64d_entry_t head,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	output logic [2:0]  m_tuser
);

	logic [1:0] k_q;
	logic       m_tvalid_q;
	logic [7:0] data_q;
	logic       done_q;
	logic [2:0] user_q;
	logic       load;
	logic       fin;
	logic [7:0] byte_sel;

	assign load = head_valid && (!m_tvalid_q || m_tready);
	assign fin  = (k_q == head.last_idx);
	assign pop  = load && fin;

	// Pick the byte of the current entry.
	always_comb begin
		case (k_q)
			2'd0:    byte_sel = head.word[23:16];
			2'd1:    byte_sel = head.word[15:8];
			2'd2:    byte_sel = head.word[7:0];
			default: byte_sel = 8'd0;
		endcase
	end

	// Byte index within the entry and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= 2'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q <= fin ? 2'd0 : k_q + 2'd1;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= byte_sel;
			done_q <= fin && head.msg_last;
			user_q <= {head.status, fin};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = done_q;
	assign m_tuser  = user_q;

`ifndef SYNTHESIS
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != 2'd3)
		else $error("byte index out of range");
	a_done_is_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && done_q) |-> user_q[0])
		else $error("message end without run end");
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && user_q[2:1] != ST_OK) |-> (data_q == 8'd0 && done_q && user_q[0]))
		else $error("error result not a single closing result");
`endif

endmodule

>>> sv/base64_stream_decoder.sv
// Top level of the streaming base64 decoder.
// Usage:
//   Slave channel: one base64 character per transfer on s_tdata, with s_tlast
//   set on the final character of a message.
//   Master channel: one decoded byte per transfer on m_tdata; m_tlast marks
//   the final result of a message, m_tuser[0] the last result caused by one
//   character and m_tuser[2:1] the status (0 ok, 1 invalid character,
//   2 bad length, 3 misplaced padding). After an error one status result
//   is sent and the rest of the message is dropped.
// Timing:
//   Characters are taken one per cycle while the queue is not full. The
//   fourth character of a quartet queues one entry; its first byte reaches
//   the master side through the queue and the single output register, and
//   the rest follow. Output is one result per cycle while m_tready is high.
// Reset and stalls:
//   arst_n clears the quartet state, the queue and the output valid flag.
//   When m_tready stays low the queue fills and s_tready falls once it is
//   full; no result is lost or repeated.
module base64_stream_decoder
	import b64d_pkg::*;
#(
	parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic       m_tlast,
	output logic [2:0] m_tuser    // [0] run_end, [2:1] status
);

	b64d_push_t  push;
	b64d_entry_t head;
	logic        queue_full;
	logic        head_valid;
	logic        pop;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_char    (s_tdata),
		.msg_end    (s_tlast),
		.queue_full (queue_full),
		.push_o     (push)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_i     (push),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
